// ===== rtl/ept_pkg.sv =====
// ----------------------------------------------------------------------------
// ept_pkg
// Constants and types shared by the encoder position tracker and its
// channel interfaces.
// ----------------------------------------------------------------------------
package ept_pkg;

    localparam int MOTORS        = 4;
    localparam int ENCODER_TICKS = 65536;
    localparam int HISTORY_DEPTH = 16;
    localparam int HALF_TICKS    = ENCODER_TICKS / 2;

    localparam int MOTOR_W    = 3;
    localparam int RAW_W      = 16;
    localparam int LOOKBACK_W = 8;
    localparam int POS_W      = 32;
    localparam int VEL_W      = 17;
    localparam int STOP_W     = 16;
    localparam int STATUS_W   = 2;

    localparam int MIDX_W       = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int PTR_W        = $clog2(HISTORY_DEPTH);
    localparam int HIST_ENTRIES = MOTORS * HISTORY_DEPTH;
    localparam int HADDR_W      = $clog2(HIST_ENTRIES);

    localparam logic [STOP_W-1:0] STOP_MAX = {STOP_W{1'b1}};

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK           = 2'd0;
    localparam status_t STATUS_BAD_MOTOR    = 2'd1;
    localparam status_t STATUS_BAD_LOOKBACK = 2'd2;

    // where the past position of a result comes from
    typedef logic [1:0] past_src_t;

    localparam past_src_t PAST_ZERO    = 2'd0;
    localparam past_src_t PAST_CURRENT = 2'd1;
    localparam past_src_t PAST_RING    = 2'd2;

endpackage

// ===== rtl/ept_ifs.sv =====
// ----------------------------------------------------------------------------
// ept channel interfaces
// Valid/ready channels for encoder samples and tracker results.
// ----------------------------------------------------------------------------
interface ept_sample_if;
    import ept_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [MOTOR_W-1:0]    motor_id;
    logic [RAW_W-1:0]      raw_count;
    logic [LOOKBACK_W-1:0] lookback;

    modport source (output valid, motor_id, raw_count, lookback, input ready);
    modport sink   (input valid, motor_id, raw_count, lookback, output ready);
endinterface

interface ept_result_if;
    import ept_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  absolute_position;
    logic signed [VEL_W-1:0]  velocity;
    logic [STOP_W-1:0]        stopped_samples;
    logic signed [POS_W-1:0]  past_position;
    status_t                  status;

    modport source (output valid, absolute_position, velocity, stopped_samples,
                    past_position, status, input ready);
    modport sink   (input valid, absolute_position, velocity, stopped_samples,
                    past_position, status, output ready);
endinterface

// ===== rtl/encoder_position_tracker_top.sv =====
// ----------------------------------------------------------------------------
// encoder_position_tracker_top
// Per-motor encoder unwrap with saturating position, velocity, stop count
// and a ring of recent positions.
// ----------------------------------------------------------------------------
// One word in, one word out, one word per cycle sustained while the output
// takes results. A sample is registered, then the unwrap, clamp and per-motor
// state update happen in one pass as it moves into the result register;
// the history ring is a memory with one write and one registered read per
// cycle, so a lookback of zero is taken from the fresh position directly.
// While a result waits on the output the input register can still take
// one word; after that the input stalls until the result is taken.
// Ring entries not yet written since reset read as zero.
// ----------------------------------------------------------------------------
module encoder_position_tracker_top (
    input  logic          clk,
    input  logic          rst_n,
    ept_sample_if.sink    sample,
    ept_result_if.source  result
);
    import ept_pkg::*;

    localparam logic signed [17:0] HALF_S  = 18'(HALF_TICKS);
    localparam logic signed [17:0] TICKS_S = 18'(ENCODER_TICKS);
    localparam logic signed [33:0] POS_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] POS_MIN = -34'sh0_8000_0000;

    // per-motor state
    logic [RAW_W-1:0]        last_raw_reg [MOTORS];
    logic signed [POS_W-1:0] abs_pos_reg  [MOTORS];
    logic [STOP_W-1:0]       stop_reg     [MOTORS];
    logic [PTR_W-1:0]        ptr_reg      [MOTORS];

    // history ring
    logic signed [POS_W-1:0] hist_mem [HIST_ENTRIES];
    logic [HIST_ENTRIES-1:0] hist_vld_reg;
    logic signed [POS_W-1:0] rd_data_reg;
    logic                    rd_vld_reg;

    // input stage
    logic                  s1_valid_reg;
    logic [MOTOR_W-1:0]    s1_motor_reg;
    logic [RAW_W-1:0]      s1_raw_reg;
    logic [LOOKBACK_W-1:0] s1_lookback_reg;

    // result stage
    logic                    s2_valid_reg;
    logic signed [POS_W-1:0] s2_pos_reg;
    logic signed [VEL_W-1:0] s2_vel_reg;
    logic [STOP_W-1:0]       s2_stop_reg;
    status_t                 s2_status_reg;
    past_src_t               s2_past_src_reg;

    logic adv2;
    logic adv1;

    logic                    motor_ok;
    logic                    lookback_ok;
    logic [MIDX_W-1:0]       midx;
    logic [RAW_W-1:0]        raw_mod;
    logic signed [17:0]      diff;
    logic signed [17:0]      step;
    logic signed [POS_W-1:0] old_pos;
    logic signed [33:0]      sum;
    logic signed [POS_W-1:0] new_pos;
    logic signed [POS_W:0]   vel_full;
    logic signed [VEL_W-1:0] vel;
    logic [STOP_W-1:0]       stop_next;
    logic [PTR_W-1:0]        ptr_next;
    logic [PTR_W-1:0]        lb_idx;
    logic [PTR_W:0]          rd_slot_wide;
    logic [PTR_W-1:0]        rd_slot;
    logic [HADDR_W-1:0]      waddr;
    logic [HADDR_W-1:0]      raddr;
    logic                    do_update;

    assign adv2         = !s2_valid_reg || result.ready;
    assign adv1         = !s1_valid_reg || adv2;
    assign sample.ready = adv1;
    assign do_update    = s1_valid_reg && adv2 && motor_ok;

    // ------------------------------------------------------------------
    // unwrap, clamp and bookkeeping for the word in the input stage
    // ------------------------------------------------------------------
    always_comb
    begin
        motor_ok    = 32'(s1_motor_reg) < MOTORS;
        lookback_ok = 32'(s1_lookback_reg) < HISTORY_DEPTH;
        midx        = s1_motor_reg[MIDX_W-1:0];
        raw_mod     = RAW_W'(32'(s1_raw_reg) % ENCODER_TICKS);

        diff = $signed({2'b00, raw_mod}) - $signed({2'b00, last_raw_reg[midx]});
        if (diff > HALF_S)
        begin
            step = diff - TICKS_S;
        end
        else if (diff < -HALF_S)
        begin
            step = diff + TICKS_S;
        end
        else
        begin
            step = diff;
        end

        old_pos = abs_pos_reg[midx];
        sum     = {{2{old_pos[POS_W-1]}}, old_pos} + {{16{step[17]}}, step};
        if (sum > POS_MAX)
        begin
            new_pos = POS_MAX[POS_W-1:0];
        end
        else if (sum < POS_MIN)
        begin
            new_pos = POS_MIN[POS_W-1:0];
        end
        else
        begin
            new_pos = sum[POS_W-1:0];
        end

        vel_full = {new_pos[POS_W-1], new_pos} - {old_pos[POS_W-1], old_pos};
        vel      = vel_full[VEL_W-1:0];

        if (vel == '0)
        begin
            stop_next = (stop_reg[midx] == STOP_MAX) ? STOP_MAX
                                                     : stop_reg[midx] + 1'b1;
        end
        else
        begin
            stop_next = '0;
        end

        if (32'(ptr_reg[midx]) >= HISTORY_DEPTH - 1)
        begin
            ptr_next = '0;
        end
        else
        begin
            ptr_next = ptr_reg[midx] + 1'b1;
        end

        lb_idx = s1_lookback_reg[PTR_W-1:0];
        if (ptr_next >= lb_idx)
        begin
            rd_slot_wide = {1'b0, ptr_next} - {1'b0, lb_idx};
        end
        else
        begin
            rd_slot_wide = {1'b0, ptr_next} + (PTR_W+1)'(HISTORY_DEPTH) - {1'b0, lb_idx};
        end
        rd_slot = rd_slot_wide[PTR_W-1:0];

        waddr = HADDR_W'(32'(midx) * HISTORY_DEPTH + 32'(ptr_next));
        raddr = HADDR_W'(32'(midx) * HISTORY_DEPTH + 32'(rd_slot));
    end

    // ------------------------------------------------------------------
    // input stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv1)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && sample.valid)
        begin
            s1_motor_reg    <= sample.motor_id;
            s1_raw_reg      <= sample.raw_count;
            s1_lookback_reg <= sample.lookback;
        end
    end

    // ------------------------------------------------------------------
    // per-motor state and ring valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MOTORS; i++)
            begin
                last_raw_reg[i] <= '0;
                abs_pos_reg[i]  <= '0;
                stop_reg[i]     <= '0;
                ptr_reg[i]      <= '0;
            end
            hist_vld_reg <= '0;
        end
        else if (do_update)
        begin
            last_raw_reg[midx]  <= raw_mod;
            abs_pos_reg[midx]   <= new_pos;
            stop_reg[midx]      <= stop_next;
            ptr_reg[midx]       <= ptr_next;
            hist_vld_reg[waddr] <= 1'b1;
        end
    end

    // ring memory: a read of the slot written at the same edge (lookback zero, bypassed,
    // or a bad lookback, reported as zero) is not used; other reads return the older entry
    always_ff @(posedge clk)
    begin
        if (do_update)
        begin
            hist_mem[waddr] <= new_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && adv2)
        begin
            rd_data_reg <= hist_mem[raddr];
            rd_vld_reg  <= hist_vld_reg[raddr];
        end
    end

    // ------------------------------------------------------------------
    // result stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && adv2)
        begin
            if (!motor_ok)
            begin
                s2_pos_reg      <= '0;
                s2_vel_reg      <= '0;
                s2_stop_reg     <= '0;
                s2_status_reg   <= STATUS_BAD_MOTOR;
                s2_past_src_reg <= PAST_ZERO;
            end
            else
            begin
                s2_pos_reg  <= new_pos;
                s2_vel_reg  <= vel;
                s2_stop_reg <= stop_next;
                if (!lookback_ok)
                begin
                    s2_status_reg   <= STATUS_BAD_LOOKBACK;
                    s2_past_src_reg <= PAST_ZERO;
                end
                else
                begin
                    s2_status_reg   <= STATUS_OK;
                    s2_past_src_reg <= (s1_lookback_reg == '0) ? PAST_CURRENT : PAST_RING;
                end
            end
        end
    end

    always_comb
    begin
        case (s2_past_src_reg)
            PAST_CURRENT: result.past_position = s2_pos_reg;
            PAST_RING:    result.past_position = rd_vld_reg ? rd_data_reg : '0;
            default:      result.past_position = '0;
        endcase
    end

    assign result.valid             = s2_valid_reg;
    assign result.absolute_position = s2_pos_reg;
    assign result.velocity          = s2_vel_reg;
    assign result.stopped_samples   = s2_stop_reg;
    assign result.status            = s2_status_reg;

endmodule

// ===== test/encoder_position_tracker_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_position_tracker_top_test
// Drives encoder samples through the tracker under several idle and stall
// patterns and checks every result word against a per-motor model of the
// unwrap, the clamp, the stop count and the position ring. Short ramps
// wrap one motor every other word in both directions and hold another
// motor still.
// ----------------------------------------------------------------------------
module encoder_position_tracker_top_test;
    import ept_pkg::*;

    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;
    localparam int     STRIDE  = HALF_TICKS - 1;

    typedef struct {
        logic signed [POS_W-1:0] position;
        logic signed [VEL_W-1:0] velocity;
        logic [STOP_W-1:0]       stopped;
        logic signed [POS_W-1:0] past;
        status_t                 status;
    } track_result_t;

    // per-motor tracking model and the results still owed by the block
    class motor_track_board;
        logic [RAW_W-1:0]  last_raw [MOTORS];
        int                abs_pos  [MOTORS];
        logic [STOP_W-1:0] stop_cnt [MOTORS];
        int                hist_ptr [MOTORS];
        int                ring     [MOTORS][HISTORY_DEPTH];
        track_result_t     due_results[$];
        int errors, n_checked, n_bad_motor, n_bad_lookback, n_wrap, n_clamp, n_stop_sat;

        function new();
            foreach (last_raw[i])
            begin
                last_raw[i] = '0;
                abs_pos[i]  = 0;
                stop_cnt[i] = '0;
                hist_ptr[i] = 0;
                foreach (ring[i][j]) ring[i][j] = 0;
            end
        endfunction

        function void note_sample(logic [MOTOR_W-1:0] m, logic [RAW_W-1:0] raw,
                                  logic [LOOKBACK_W-1:0] lb);
            track_result_t r;
            int mi, cur, diff, ptr, new_pos;
            longint step, sum, vel;
            r = '{default: '0};
            mi = int'(m);
            if (mi >= MOTORS)
            begin
                r.status = STATUS_BAD_MOTOR;
                n_bad_motor++;
            end
            else
            begin
                cur  = int'(raw) % ENCODER_TICKS;
                diff = cur - int'(last_raw[mi]);
                if (diff > HALF_TICKS)
                    step = diff - ENCODER_TICKS;
                else if (diff < -HALF_TICKS)
                    step = diff + ENCODER_TICKS;
                else
                    step = diff;
                if (step != diff)
                    n_wrap++;
                sum = longint'(abs_pos[mi]) + step;
                if (sum > POS_MAX)
                    new_pos = int'(POS_MAX);
                else if (sum < POS_MIN)
                    new_pos = int'(POS_MIN);
                else
                    new_pos = int'(sum);
                if (sum != longint'(new_pos))
                    n_clamp++;
                last_raw[mi] = RAW_W'(cur);
                ptr = (hist_ptr[mi] + 1) % HISTORY_DEPTH;
                hist_ptr[mi] = ptr;
                ring[mi][ptr] = new_pos;
                vel = longint'(new_pos) - longint'(abs_pos[mi]);
                abs_pos[mi] = new_pos;
                if (vel != 0)
                    stop_cnt[mi] = '0;
                else if (stop_cnt[mi] != STOP_MAX)
                    stop_cnt[mi] = stop_cnt[mi] + 1'b1;
                else
                    n_stop_sat++;
                r.position = new_pos;
                r.velocity = vel[VEL_W-1:0];
                r.stopped  = stop_cnt[mi];
                if (int'(lb) >= HISTORY_DEPTH)
                begin
                    r.status = STATUS_BAD_LOOKBACK;
                    n_bad_lookback++;
                end
                else
                begin
                    r.status = STATUS_OK;
                    r.past   = ring[mi][(ptr - int'(lb) + HISTORY_DEPTH) % HISTORY_DEPTH];
                end
            end
            due_results.push_back(r);
        endfunction

        function void flag(string field, longint want, longint got);
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(logic signed [POS_W-1:0] position,
                                   logic signed [VEL_W-1:0] velocity,
                                   logic [STOP_W-1:0] stopped,
                                   logic signed [POS_W-1:0] past, status_t status);
            track_result_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t ns: result word with none expected, expected nothing, got pos %0d status %0d",
                         $time, position, status);
                errors++;
                return;
            end
            want = due_results.pop_front();
            n_checked++;
            if (position !== want.position) flag("absolute_position", want.position, position);
            if (velocity !== want.velocity) flag("velocity", want.velocity, velocity);
            if (stopped !== want.stopped)   flag("stopped_samples", want.stopped, stopped);
            if (past !== want.past)         flag("past_position", want.past, past);
            if (status !== want.status)     flag("status", want.status, status);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   snk_stall_pct;
    motor_track_board board;

    ept_sample_if sample_ch ();
    ept_result_if result_ch ();

    encoder_position_tracker_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("FAIL encoder_position_tracker_top");
        $finish;
    end

    // receiver: ready changes on the falling edge, words taken on the rising edge
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready = ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            board.check_result(result_ch.absolute_position, result_ch.velocity,
                               result_ch.stopped_samples, result_ch.past_position,
                               result_ch.status);
    end

    // entered and left at a falling edge; valid stays high into the next call
    task automatic send_sample(input logic [MOTOR_W-1:0] m, input logic [RAW_W-1:0] raw,
                               input logic [LOOKBACK_W-1:0] lb);
        while ($urandom_range(99) < src_idle_pct)
        begin
            sample_ch.valid = 1'b0;
            @(negedge clk);
        end
        sample_ch.valid     = 1'b1;
        sample_ch.motor_id  = m;
        sample_ch.raw_count = raw;
        sample_ch.lookback  = lb;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
        board.note_sample(m, raw, lb);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        sample_ch.valid = 1'b0;
        while (board.due_results.size() != 0) @(negedge clk);
    endtask

    task automatic set_idling(input int src, input int snk);
        wait_drained();
        src_idle_pct  = src;
        snk_stall_pct = snk;
    endtask

    // steady stride given by the caller; just under half a turn wraps every other word
    task automatic ramp_motor(input int m, input int stride, input int count);
        logic [RAW_W-1:0] raw;
        raw = board.last_raw[m];
        repeat (count)
        begin
            raw = raw + RAW_W'(stride);
            send_sample(MOTOR_W'(m), raw, LOOKBACK_W'($urandom_range(0, HISTORY_DEPTH - 1)));
        end
    endtask

    task automatic random_sample();
        int m, pick;
        logic [RAW_W-1:0] raw;
        logic [LOOKBACK_W-1:0] lb;
        if ($urandom_range(99) < 8)
            m = $urandom_range(MOTORS, (1 << MOTOR_W) - 1);
        else
            m = $urandom_range(0, MOTORS - 1);
        raw  = (m < MOTORS) ? board.last_raw[m] : '0;
        pick = $urandom_range(99);
        if (pick < 40)
            raw = raw + RAW_W'($urandom_range(0, 64)) - RAW_W'(32);
        else if (pick < 60)
            raw = raw + RAW_W'(HALF_TICKS) + RAW_W'($urandom_range(0, 4)) - RAW_W'(2);
        else if (pick >= 70)
            raw = RAW_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 85)
            lb = LOOKBACK_W'($urandom_range(0, HISTORY_DEPTH - 1));
        else
            lb = LOOKBACK_W'($urandom_range(HISTORY_DEPTH, (1 << LOOKBACK_W) - 1));
        if ($urandom_range(99) < 2)
            wait_drained();
        send_sample(MOTOR_W'(m), raw, lb);
    endtask

    initial
    begin
        board         = new();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        rst_n                 = 1'b0;
        sample_ch.valid       = 1'b0;
        sample_ch.motor_id    = '0;
        sample_ch.raw_count   = '0;
        sample_ch.lookback    = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: half-turn boundaries, wraps both ways, bad words, field extremes
        send_sample(3'd0, 16'd0, 8'd0);
        send_sample(3'd0, 16'd32768, 8'd1);
        send_sample(3'd0, 16'd0, 8'd2);
        send_sample(3'd0, 16'd32769, 8'd0);
        send_sample(3'd0, 16'd0, 8'd15);
        send_sample(3'd0, 16'hFFFF, 8'd16);
        send_sample(3'd0, 16'd0, 8'd255);
        send_sample(3'd1, 16'hFFFF, 8'd3);
        send_sample(3'd1, 16'h5555, 8'h55);
        send_sample(3'd1, 16'hAAAA, 8'hAA);
        send_sample(3'd3, 16'd100, 8'd0);
        send_sample(3'd4, 16'd1234, 8'd0);
        send_sample(3'd5, 16'hFFFF, 8'd15);
        send_sample(3'd6, 16'h8000, 8'd7);
        send_sample(3'd7, 16'hFFFF, 8'd255);
        send_sample(3'd2, 16'd0, 8'd0);
        send_sample(3'd2, 16'd0, 8'd1);
        send_sample(3'd2, 16'd0, 8'd14);
        send_sample(3'd2, 16'd1, 8'd0);
        send_sample(3'd3, 16'h7FFF, 8'd8);
        send_sample(3'd3, 16'hFFFF, 8'd4);

        // hold-off: nothing sent until the pipe is empty
        wait_drained();
        repeat (5) @(negedge clk);

        set_idling(0, 0);
        repeat (450) random_sample();
        set_idling(52, 0);
        repeat (450) random_sample();
        set_idling(0, 52);
        repeat (450) random_sample();
        set_idling(15, 15);
        repeat (450) random_sample();

        // near half-turn strides on motor 3, forward, backward, then forward again
        set_idling(0, 0);
        ramp_motor(3, STRIDE, 40);
        set_idling(15, 15);
        ramp_motor(3, -STRIDE, 40);
        ramp_motor(3, STRIDE, 20);

        // motor 2 held still, then nudged
        set_idling(0, 0);
        ramp_motor(2, 0, 40);
        ramp_motor(2, 1, 3);

        set_idling(52, 52);
        repeat (100) random_sample();

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Checked %0d result words: %0d wraps, %0d clamped positions, %0d saturated stop counts,",
                 board.n_checked, board.n_wrap, board.n_clamp, board.n_stop_sat);
        $display("%0d bad motor words, %0d bad lookbacks, %0d mismatches.",
                 board.n_bad_motor, board.n_bad_lookback, board.errors);
        if (board.errors == 0)
            $display("PASS encoder_position_tracker_top");
        else
            $display("FAIL encoder_position_tracker_top");
        $finish;
    end

endmodule
